// File: rtl/fmpl_pkg.sv
package fmpl_pkg;

  localparam int unsigned NumMotors = 4;

  // reset values of the coefficient registers
  localparam logic [31:0] TorqueRst = 32'd562074549;
  localparam logic [31:0] CurSqRst  = 32'd34621422;
  localparam logic [31:0] SpdSqRst  = 32'd40898314;
  localparam logic [15:0] StaticRst = 16'd1045;
  localparam logic [14:0] CurLimRst = 15'd16000;

  localparam logic [21:0] EstMax = 22'h3FFFFF;

  // iteration counts of the back-end sequencer
  localparam logic [5:0] DivSteps  = 6'd59;
  localparam logic [5:0] MulSteps  = 6'd48;
  localparam logic [5:0] SqrtSteps = 6'd49;

  typedef enum logic [2:0] {
    CFG_TORQUE  = 3'd0,
    CFG_CUR_SQ  = 3'd1,
    CFG_SPD_SQ  = 3'd2,
    CFG_STATIC  = 3'd3,
    CFG_CUR_LIM = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] torque;
    logic [31:0] cur_sq;
    logic [31:0] spd_sq;
    logic [15:0] static_pw;
    logic [14:0] cur_lim;
  } cfg_t;

  // one classified request, as handed from the estimator to the solver
  typedef struct packed {
    logic [3:0][15:0] cur;
    logic [3:0][15:0] spd;
    logic [3:0][30:0] spd2;    // speed squared
    logic [3:0][33:0] pw;      // signed estimate, Q16
    logic [25:0]      budget;  // Q16
    logic [34:0]      total;   // Q16
    logic [21:0]      est;
    logic             scaled;
  } item_t;

endpackage

// File: rtl/fmpl_front.sv
module fmpl_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fmpl_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [17:0]           power_limit,
  input  logic [3:0][15:0]      cur,
  input  logic [3:0][15:0]      spd,
  input  logic                  q_full,
  output logic                  push,
  output fmpl_pkg::item_t       item
);

  logic rdy_r, v1_r, v2_r, v3_r, v4_r;
  logic en, accept;

  logic [25:0]       bud1_r, bud2_r, bud3_r;
  logic [3:0][15:0]  cur1_r, cur2_r, cur3_r;
  logic [3:0][15:0]  spd1_r, spd2_r, spd3_r;
  logic [3:0][31:0]  iw1_r;
  logic [3:0][30:0]  cq1_r;
  logic [3:0][30:0]  sq1_r, sq2_r, sq3_r;
  logic [3:0][31:0]  tt2_r;
  logic [3:0][30:0]  a2_r, b2_r;
  logic [3:0][33:0]  pw3_r;
  fmpl_pkg::item_t   item4_r;

  logic signed [31:0] iw_nxt [fmpl_pkg::NumMotors];
  logic signed [31:0] cq_nxt [fmpl_pkg::NumMotors];
  logic signed [31:0] sq_nxt [fmpl_pkg::NumMotors];
  logic signed [63:0] tp_nxt [fmpl_pkg::NumMotors];
  logic [62:0]        ap_nxt [fmpl_pkg::NumMotors];
  logic [62:0]        bp_nxt [fmpl_pkg::NumMotors];
  logic [33:0]        pw_nxt [fmpl_pkg::NumMotors];
  logic [34:0]        tot_nxt;
  logic [26:0]        est_wide;
  logic [21:0]        est_nxt;

  assign en       = !(v4_r && q_full);
  assign in_ready = rdy_r && en;
  assign accept   = in_valid && in_ready;
  assign push     = v4_r && !q_full;
  assign item     = item4_r;

  always_comb begin
    for (int m = 0; m < fmpl_pkg::NumMotors; m++) begin
      iw_nxt[m] = $signed(cur[m]) * $signed(spd[m]);
      cq_nxt[m] = $signed(cur[m]) * $signed(cur[m]);
      sq_nxt[m] = $signed(spd[m]) * $signed(spd[m]);
      // arithmetic shift of the product floors toward minus infinity
      tp_nxt[m] = $signed(iw1_r[m]) * $signed({1'b0, cfg.torque});
      ap_nxt[m] = cfg.cur_sq * cq1_r[m];
      bp_nxt[m] = cfg.spd_sq * sq1_r[m];
      pw_nxt[m] = 34'($signed(tt2_r[m])) + {3'b000, a2_r[m]} + {3'b000, b2_r[m]}
                + {10'h000, cfg.static_pw, 8'h00};
    end
    tot_nxt = '0;
    for (int m = 0; m < fmpl_pkg::NumMotors; m++) begin
      if (!pw3_r[m][33]) begin
        tot_nxt = tot_nxt + {1'b0, pw3_r[m]};
      end
    end
    est_wide = tot_nxt[34:8];
    est_nxt  = (|est_wide[26:22]) ? fmpl_pkg::EstMax : est_wide[21:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdy_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
    end else begin
      rdy_r <= 1'b1;
      if (en) begin
        v1_r <= accept;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bud1_r <= {power_limit, 8'h00};
      cur1_r <= cur;
      spd1_r <= spd;
      for (int m = 0; m < fmpl_pkg::NumMotors; m++) begin
        iw1_r[m] <= iw_nxt[m];
        cq1_r[m] <= cq_nxt[m][30:0];
        sq1_r[m] <= sq_nxt[m][30:0];
        tt2_r[m] <= tp_nxt[m][63:32];
        a2_r[m]  <= ap_nxt[m][62:32];
        b2_r[m]  <= bp_nxt[m][62:32];
        pw3_r[m] <= pw_nxt[m];
      end
      bud2_r <= bud1_r;
      cur2_r <= cur1_r;
      spd2_r <= spd1_r;
      sq2_r  <= sq1_r;
      bud3_r <= bud2_r;
      cur3_r <= cur2_r;
      spd3_r <= spd2_r;
      sq3_r  <= sq2_r;
      item4_r.cur    <= cur3_r;
      item4_r.spd    <= spd3_r;
      item4_r.spd2   <= sq3_r;
      item4_r.pw     <= pw3_r;
      item4_r.budget <= bud3_r;
      item4_r.total  <= tot_nxt;
      item4_r.est    <= est_nxt;
      item4_r.scaled <= tot_nxt > {9'h000, bud3_r};
    end
  end

endmodule

// File: rtl/fmpl_queue.sv
module fmpl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fmpl_pkg::item_t din,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output fmpl_pkg::item_t dout
);

  fmpl_pkg::item_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;

  assign full  = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

// File: rtl/fmpl_back.sv
module fmpl_back (
  input  logic             clk,
  input  logic             rst_n,
  input  fmpl_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  fmpl_pkg::item_t  q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [3:0][15:0] out_cur,
  output logic [21:0]      out_est,
  output logic             out_scaled
);

  typedef enum logic [3:0] {
    B_IDLE, B_SEL, B_COEF, B_C, B_MUL, B_DISC, B_SQRT, B_NUM, B_DIV, B_RES, B_DONE
  } state_t;

  state_t            state_r;
  fmpl_pkg::item_t   item_r;
  logic [1:0]        m_r;
  logic [3:0][15:0]  res_r;
  logic [47:0]       bmag_r, mb_r, mk_r;
  logic [62:0]       ca_r, cmag_r;
  logic              cpos_r, nneg_r, ph_r;
  logic [95:0]       bb_r;
  logic [94:0]       kc_r;
  logic [97:0]       x_r;
  logic [48:0]       rt_r;
  logic [51:0]       rm_r;
  logic [58:0]       dn_r;  // dividend in, quotient out
  logic [35:0]       dr_r;
  logic [34:0]       dd_r;
  logic [5:0]        cnt_r;
  logic              ov_r, osc_r;
  logic [3:0][15:0]  ocur_r;
  logic [21:0]       oest_r;

  logic [15:0] cur_m, spd_m, spd_mag, lim16, q_sat;
  logic [33:0] pw_m;
  logic        cur_pos, last_m;
  logic [58:0] ps_prod;
  logic [35:0] dv_rem, dv_diff;
  logic        dv_ge;
  logic [63:0] c_val;
  logic [62:0] c_mag;
  logic [96:0] kc4;
  logic [97:0] disc;
  logic [51:0] sq_rem, sq_trial, b_sgn, num, num_mag;
  logic        sq_ge;

  assign q_pop      = (state_r == B_IDLE) && q_valid;
  assign out_valid  = ov_r;
  assign out_cur    = ocur_r;
  assign out_est    = oest_r;
  assign out_scaled = osc_r;

  always_comb begin
    cur_m   = item_r.cur[m_r];
    spd_m   = item_r.spd[m_r];
    pw_m    = item_r.pw[m_r];
    cur_pos = !cur_m[15] && (cur_m != 16'h0000);
    last_m  = m_r == 2'd3;
    spd_mag = spd_m[15] ? (16'h0000 - spd_m) : spd_m;
    lim16   = {1'b0, cfg.cur_lim};
    ps_prod = pw_m[32:0] * item_r.budget;
    dv_rem  = {dr_r[34:0], dn_r[58]};
    dv_ge   = dv_rem >= {1'b0, dd_r};
    dv_diff = dv_rem - {1'b0, dd_r};
    c_val   = {1'b0, ca_r} + {8'h00, cfg.static_pw, 40'h0} - {6'h00, dn_r[25:0], 32'h0};
    c_mag   = c_val[63] ? 63'(64'h0 - c_val) : c_val[62:0];
    kc4     = {kc_r, 2'b00};
    if (!cpos_r) begin
      disc = {2'b00, bb_r} + {1'b0, kc4};
    end else if ({1'b0, bb_r} >= kc4) begin
      disc = {2'b00, bb_r} - {1'b0, kc4};
    end else begin
      disc = '0;  // negative discriminant clamps to zero
    end
    sq_rem   = {rm_r[49:0], x_r[97:96]};
    sq_trial = {1'b0, rt_r, 2'b01};
    sq_ge    = sq_rem >= sq_trial;
    b_sgn    = spd_m[15] ? (52'h0 - {4'h0, bmag_r}) : {4'h0, bmag_r};
    num      = cur_pos ? ({3'b000, rt_r} - b_sgn) : (52'h0 - b_sgn - {3'b000, rt_r});
    num_mag  = num[51] ? (52'h0 - num) : num;
    q_sat    = (dn_r > {44'h0, cfg.cur_lim}) ? lim16 : dn_r[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      // B_DONE drives ov_r itself
      if (out_ready && (state_r != B_DONE)) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            m_r     <= 2'd0;
            state_r <= B_SEL;
          end
        end
        B_SEL: begin
          if (!item_r.scaled || pw_m[33] || (cfg.cur_sq == 32'h0)) begin
            if (!item_r.scaled || pw_m[33]) begin
              res_r[m_r] <= cur_m;
            end else begin
              res_r[m_r] <= cur_pos ? lim16 : (16'h0000 - lim16);
            end
            m_r     <= m_r + 2'd1;
            state_r <= last_m ? B_DONE : B_SEL;
          end else begin
            dn_r    <= ps_prod;
            dr_r    <= '0;
            dd_r    <= item_r.total;
            ph_r    <= 1'b0;
            cnt_r   <= fmpl_pkg::DivSteps;
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          dr_r  <= dv_ge ? dv_diff : dv_rem;
          dn_r  <= {dn_r[57:0], dv_ge};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            state_r <= ph_r ? B_RES : B_COEF;
          end
        end
        B_COEF: begin
          bmag_r  <= cfg.torque * spd_mag;
          ca_r    <= cfg.spd_sq * item_r.spd2[m_r];
          state_r <= B_C;
        end
        B_C: begin
          cmag_r  <= c_mag;
          cpos_r  <= !c_val[63] && (c_val != 64'h0);
          mb_r    <= bmag_r;
          mk_r    <= {16'h0000, cfg.cur_sq};
          bb_r    <= '0;
          kc_r    <= '0;
          cnt_r   <= fmpl_pkg::MulSteps;
          state_r <= B_MUL;
        end
        B_MUL: begin
          // shift-add, multiplier bits taken msb first
          bb_r  <= {bb_r[94:0], 1'b0} + (mb_r[47] ? {48'h0, bmag_r} : 96'h0);
          kc_r  <= {kc_r[93:0], 1'b0} + (mk_r[47] ? {32'h0, cmag_r} : 95'h0);
          mb_r  <= {mb_r[46:0], 1'b0};
          mk_r  <= {mk_r[46:0], 1'b0};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            state_r <= B_DISC;
          end
        end
        B_DISC: begin
          x_r     <= disc;
          rt_r    <= '0;
          rm_r    <= '0;
          cnt_r   <= fmpl_pkg::SqrtSteps;
          state_r <= B_SQRT;
        end
        B_SQRT: begin
          rm_r  <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
          rt_r  <= {rt_r[47:0], sq_ge};
          x_r   <= {x_r[95:0], 2'b00};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            state_r <= B_NUM;
          end
        end
        B_NUM: begin
          nneg_r  <= num[51];
          dn_r    <= {7'h00, num_mag};
          dr_r    <= '0;
          dd_r    <= {2'b00, cfg.cur_sq, 1'b0};
          ph_r    <= 1'b1;
          cnt_r   <= fmpl_pkg::DivSteps;
          state_r <= B_DIV;
        end
        B_RES: begin
          res_r[m_r] <= nneg_r ? (16'h0000 - q_sat) : q_sat;
          m_r        <= m_r + 2'd1;
          state_r    <= last_m ? B_DONE : B_SEL;
        end
        B_DONE: begin
          if (!ov_r || out_ready) begin
            ov_r    <= 1'b1;
            ocur_r  <= res_r;
            oest_r  <= item_r.est;
            osc_r   <= item_r.scaled;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/four_motor_power_limiter_unit.sv
// Four-motor power limiter.
// Input channel (in_*): one transaction carries the power budget and the four
// motor current commands and speeds. Output channel (out_*): one transaction
// per input with the limited currents, the summed estimate and a scaled flag.
// Configuration: cfg_we writes cfg_wdata into coefficient register cfg_index
// on a rising edge; write only while no transaction is in flight.
// Timing: a four-stage estimator pipeline takes one transaction per cycle unless
// a full queue stalls it, and feeds a two-entry queue. The solver sequencer
// drains the queue: a request inside the budget passes its currents through;
// every motor that is re-solved runs two 59-step divisions, a 48-step shift-add
// multiplier and a 49-step square root, all in one shared sequencer.
// Reset: rst_n is synchronous; pipeline, queue and output register empty,
// coefficients return to their defaults; in_tready rises the cycle after release.
// Stall: a held output keeps its value; the estimator keeps accepting until
// the queue is full and its last stage holds a transaction, then drops in_tready.
module four_motor_power_limiter_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // power_limit_q8[17:0], motor_current_0..3[81:18], motor_speed_0..3[145:82]
  input  logic [151:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // limited_current_0..3[63:0], estimated_power_q8[85:64]
  output logic [87:0]  out_tdata,
  // was_scaled
  output logic         out_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  fmpl_pkg::cfg_t  cfg_r;
  fmpl_pkg::item_t f_item, q_item;
  logic            f_push, q_full, q_valid, q_pop;
  logic [3:0][15:0] in_cur, in_spd, lim_cur;
  logic [21:0]     est;
  logic            scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.torque    <= fmpl_pkg::TorqueRst;
      cfg_r.cur_sq    <= fmpl_pkg::CurSqRst;
      cfg_r.spd_sq    <= fmpl_pkg::SpdSqRst;
      cfg_r.static_pw <= fmpl_pkg::StaticRst;
      cfg_r.cur_lim   <= fmpl_pkg::CurLimRst;
    end else if (cfg_we) begin
      unique case (fmpl_pkg::cfg_idx_t'(cfg_index))
        fmpl_pkg::CFG_TORQUE:  cfg_r.torque    <= cfg_wdata;
        fmpl_pkg::CFG_CUR_SQ:  cfg_r.cur_sq    <= cfg_wdata;
        fmpl_pkg::CFG_SPD_SQ:  cfg_r.spd_sq    <= cfg_wdata;
        fmpl_pkg::CFG_STATIC:  cfg_r.static_pw <= cfg_wdata[15:0];
        fmpl_pkg::CFG_CUR_LIM: cfg_r.cur_lim   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  assign in_cur = in_tdata[81:18];
  assign in_spd = in_tdata[145:82];

  fmpl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .power_limit (in_tdata[17:0]),
    .cur         (in_cur),
    .spd         (in_spd),
    .q_full      (q_full),
    .push        (f_push),
    .item        (f_item)
  );

  fmpl_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_item)
  );

  fmpl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_cur    (lim_cur),
    .out_est    (est),
    .out_scaled (scaled)
  );

  assign out_tdata = {2'b00, est, lim_cur};
  assign out_tuser = scaled;

endmodule

// File: rtl/fmpl_checker.sv
module fmpl_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [87:0]  out_tdata,
  input logic         out_tuser
);

  logic [3:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 4'd0;
    end else begin
      pend_r <= pend_r + {3'b000, in_acc} - {3'b000, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output payload changed while stalled");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 4'd0)
    else $error("result without an outstanding request");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd8)
    else $error("more requests in flight than storage holds");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("channels active right after reset");

endmodule

bind four_motor_power_limiter_unit fmpl_checker u_fmpl_checker (.*);

// File: tb/four_motor_power_limiter_unit_tb.sv
module four_motor_power_limiter_unit_tb;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 1000;

  typedef struct {
    bit [15:0] cur [4];
    bit [21:0] est;
    bit        scaled;
  } limit_result_t;

  class limiter_scoreboard;
    bit [63:0] torque, k1, k2, stat, lim;
    limit_result_t pending_q[$];
    int mismatches;

    function new();
      torque = fmpl_pkg::TorqueRst;
      k1 = fmpl_pkg::CurSqRst;
      k2 = fmpl_pkg::SpdSqRst;
      stat = fmpl_pkg::StaticRst;
      lim = fmpl_pkg::CurLimRst;
      mismatches = 0;
    endfunction

    function void set_reg(fmpl_pkg::cfg_idx_t idx, bit [31:0] v);
      case (idx)
        fmpl_pkg::CFG_TORQUE:  torque = v;
        fmpl_pkg::CFG_CUR_SQ:  k1 = v;
        fmpl_pkg::CFG_SPD_SQ:  k2 = v;
        fmpl_pkg::CFG_STATIC:  stat = v[15:0];
        fmpl_pkg::CFG_CUR_LIM: lim = v[14:0];
        default: ;
      endcase
    endfunction

    function bit [63:0] mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    // per-motor power estimate, Q16 watts
    function longint motor_power(longint cur, longint spd);
      longint iw, tt, a, b;
      bit [63:0] t;
      iw = cur * spd;
      t = torque * mag(iw);
      tt = iw < 0 ? -longint'((t + 64'hFFFF_FFFF) >> 32) : longint'(t >> 32);
      a = longint'((k1 * 64'(cur * cur)) >> 32);
      b = longint'((k2 * 64'(spd * spd)) >> 32);
      return tt + a + b + longint'(stat << 8);
    endfunction

    // solve the power quadratic for the current at scaled power ps
    function longint solve_current(longint cur, longint spd, longint ps);
      longint b, c, num, res, l;
      bit [63:0] mb, mc, root, t;
      bit [127:0] bb, kc, disc;
      l = longint'(lim);
      if (k1 == 0) return cur > 0 ? l : -l;
      b = longint'(torque * mag(spd));
      if (spd < 0) b = -b;
      c = longint'(k2 * 64'(spd * spd)) + longint'(stat << 40) - longint'(64'(ps) << 32);
      mb = mag(b);
      mc = mag(c);
      bb = {64'd0, mb} * {64'd0, mb};
      kc = {64'd0, 64'(k1 * 4)} * {64'd0, mc};
      if (c <= 0) disc = bb + kc;
      else if (bb >= kc) disc = bb - kc;
      else disc = '0;
      root = 0;
      for (int s = 56; s >= 0; s--) begin
        t = root | (64'd1 << s);
        if (disc >= {64'd0, t} * {64'd0, t}) root = t;
      end
      num = cur > 0 ? -b + longint'(root) : -b - longint'(root);
      res = num / longint'(k1 * 2);
      if (res > l) res = l;
      if (res < -l) res = -l;
      return res;
    endfunction

    function void note_request(bit [151:0] d);
      longint cur[4], spd[4], pw[4], total, budget;
      limit_result_t r;
      total = 0;
      budget = longint'(d[17:0]) << 8;
      for (int i = 0; i < 4; i++) begin
        cur[i] = longint'($signed(d[18 + 16*i +: 16]));
        spd[i] = longint'($signed(d[82 + 16*i +: 16]));
        pw[i] = motor_power(cur[i], spd[i]);
        r.cur[i] = cur[i][15:0];
        if (pw[i] >= 0) total += pw[i];
      end
      r.scaled = total > budget;
      if (r.scaled)
        for (int i = 0; i < 4; i++)
          if (pw[i] >= 0)
            r.cur[i] = 16'(solve_current(cur[i], spd[i], (pw[i] * budget) / total));
      r.est = (total >> 8) > longint'(fmpl_pkg::EstMax) ? fmpl_pkg::EstMax : 22'(total >> 8);
      pending_q.push_back(r);
    endfunction

    function void check_result(bit [87:0] d, bit scaled);
      limit_result_t e;
      bit bad;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", d);
        return;
      end
      e = pending_q.pop_front();
      bad = scaled != e.scaled || d[85:64] != e.est;
      for (int i = 0; i < 4; i++) bad |= d[16*i +: 16] != e.cur[i];
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: exp cur %h %h %h %h est %h sc %b / got cur %h %h %h %h est %h sc %b",
                   e.cur[0], e.cur[1], e.cur[2], e.cur[3], e.est, e.scaled,
                   d[15:0], d[31:16], d[47:32], d[63:48], d[85:64], scaled);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [151:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [87:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 0;
  logic [2:0] cfg_index = fmpl_pkg::CFG_TORQUE;
  logic [31:0] cfg_wdata = '0;

  bit no_gap_in, no_gap_out;
  int unsigned cycles = 0;
  limiter_scoreboard sb = new();

  four_motor_power_limiter_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk)
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tdata);

  initial begin
    int gap;
    forever begin
      gap = no_gap_out ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      do @(posedge clk); while (!(rst_n && out_tvalid));
      sb.check_result(out_tdata, out_tuser);
    end
  end

  function automatic bit [151:0] pack_request(bit [17:0] budget, bit [15:0] c0, c1, c2, c3,
                                              bit [15:0] w0, w1, w2, w3);
    return {w3, w2, w1, w0, c3, c2, c1, c0, budget};
  endfunction

  task automatic send(bit [151:0] d);
    int gap;
    gap = no_gap_in ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    // let the clock tick so the last accepted transaction is on the scoreboard
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(fmpl_pkg::cfg_idx_t idx, bit [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  function automatic bit [15:0] rand_current();
    case ($urandom_range(0, 9))
      0: return 16'($urandom());
      1: return 16'd0;
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic bit [17:0] rand_budget();
    case ($urandom_range(0, 5))
      0: return 18'd0;
      1: return 18'($urandom());
      default: return 18'($urandom_range(0, 60000));
    endcase
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        no_gap_in = $urandom_range(0, 3) == 0;
        no_gap_out = $urandom_range(0, 3) == 0;
      end
      // hold off once until everything in flight has come back
      if (i == n / 2) begin
        in_tvalid <= 0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
      end
      send(pack_request(rand_budget(), rand_current(), rand_current(), rand_current(),
                        rand_current(), 16'($urandom()), 16'($urandom()),
                        16'($urandom()), 16'($urandom())));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // directed, default coefficients
    send(pack_request(18'h3FFFF, 16'd100, 16'd0, -16'sd50, 16'd1, 16'd10, 16'd0, 16'd20, 16'd0));
    send(pack_request(18'd0, 16'd16384, -16'sd16384, 16'd0, 16'd1000,
                      16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
    send(pack_request(18'd0, 16'd16384, 16'd16384, -16'sd16384, -16'sd16384,
                      16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
    // opposite signs give a negative estimate on those motors
    send(pack_request(18'd500, 16'd16384, -16'sd16384, 16'd8000, 16'd0,
                      16'h8000, 16'h7FFF, 16'd9000, 16'd0));
    send(pack_request(18'h3FFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
                      16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001));
    send(pack_request(18'd2000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd5000, -16'sd5000, 16'd0, 16'd1));
    send(pack_request(18'd1, 16'd3000, -16'sd3000, 16'd12000, -16'sd12000,
                      16'd2000, 16'd2000, -16'sd6000, 16'd6000));
    send(pack_request(18'h2AAAA, 16'h5555, 16'hAAAA, 16'h3FFF, 16'hC001,
                      16'h5555, 16'hAAAA, 16'h1234, 16'hEDCB));
    random_items(90);
    drain();

    // no copper loss term: solver clamps straight to the limit
    write_reg(fmpl_pkg::CFG_CUR_SQ, 32'd0);
    write_reg(fmpl_pkg::CFG_CUR_LIM, 32'd16384);
    send(pack_request(18'd0, 16'd5000, -16'sd5000, 16'd0, 16'd1, 16'd100, 16'd100, 16'd100, 16'd0));
    random_items(60);
    drain();

    // all coefficients at their maximum
    write_reg(fmpl_pkg::CFG_TORQUE, 32'hFFFF_FFFF);
    write_reg(fmpl_pkg::CFG_CUR_SQ, 32'hFFFF_FFFF);
    write_reg(fmpl_pkg::CFG_SPD_SQ, 32'hFFFF_FFFF);
    write_reg(fmpl_pkg::CFG_STATIC, 32'hFFFF);
    write_reg(fmpl_pkg::CFG_CUR_LIM, 32'h7FFF);
    send(pack_request(18'h3FFFF, 16'd16384, -16'sd16384, 16'h7FFF, 16'h8000,
                      16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
    random_items(70);
    drain();

    // everything zero but the copper loss coefficient, which is one
    write_reg(fmpl_pkg::CFG_TORQUE, 32'd0);
    write_reg(fmpl_pkg::CFG_CUR_SQ, 32'd1);
    write_reg(fmpl_pkg::CFG_SPD_SQ, 32'd0);
    write_reg(fmpl_pkg::CFG_STATIC, 32'd0);
    write_reg(fmpl_pkg::CFG_CUR_LIM, 32'd0);
    random_items(50);
    drain();

    // random settings near the defaults
    for (int p = 0; p < 3; p++) begin
      write_reg(fmpl_pkg::CFG_TORQUE, $urandom_range(100000000, 1000000000));
      write_reg(fmpl_pkg::CFG_CUR_SQ, $urandom_range(1, 100000000));
      write_reg(fmpl_pkg::CFG_SPD_SQ, $urandom_range(0, 100000000));
      write_reg(fmpl_pkg::CFG_STATIC, $urandom_range(0, 65535));
      write_reg(fmpl_pkg::CFG_CUR_LIM, $urandom_range(0, 16384));
      random_items(50);
      drain();
    end

    no_gap_in = 0;
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: filelist.f
rtl/fmpl_pkg.sv
rtl/fmpl_front.sv
rtl/fmpl_queue.sv
rtl/fmpl_back.sv
rtl/four_motor_power_limiter_unit.sv
rtl/fmpl_checker.sv
tb/four_motor_power_limiter_unit_tb.sv
